[src/ohp_pkg.sv]
// Shared types, constants and direction ROM helpers for the orientation histogram.
`timescale 1ns / 1ps
`default_nettype none
package ohp_pkg;

  localparam int CountW   = 16;
  localparam int IdxW     = 8;
  localparam int SupportW = 18;

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;

  // Token walking down the cell row during bin assignment.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [31:0]        bestv;
    logic [IdxW-1:0]    best;
    logic [31:0]        pend;
    logic [IdxW-1:0]    pidx;
  } token_t;

  typedef struct packed {
    logic            shift;
    logic            inc;
    logic            clr;
    logic [IdxW-1:0] sel;
  } cell_ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLASS = 6'b000010,
    ST_INC   = 6'b000100,
    ST_SCAN1 = 6'b001000,
    ST_POINT = 6'b010000,
    ST_SCAN2 = 6'b100000
  } state_e;

  // Q30 series sum to Q1.15: negative clamps to 0, round half up, saturate.
  function automatic logic signed [15:0] q15_sat(longint v);
    longint r;
    if (v < 0) v = 0;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return 16'(r);
  endfunction

endpackage
`default_nettype wire

[src/ohp_cell.sv]
// One histogram cell: a direction's dot-product stage plus that bin's count.
`timescale 1ns / 1ps
`default_nettype none
module ohp_cell import ohp_pkg::*; #(
  parameter int                 IDX       = 0,
  parameter logic signed [15:0] COS       = 16'sd32767,
  parameter logic signed [15:0] SIN       = 16'sd0,
  parameter int                 MAX_COUNT = 65535
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire token_t            tok_i,
  output      token_t            tok_o,
  input  wire logic [CountW-1:0] nbr_count_i,
  output      logic [CountW-1:0] count_o
);

  token_t             tok_d, tok_q;
  logic [CountW-1:0]  count_d, count_q;
  logic signed [31:0] prod_x, prod_y;
  logic signed [32:0] dot;

  always_comb begin
    prod_x = tok_i.nx * COS;
    prod_y = tok_i.ny * SIN;
    dot    = prod_x + prod_y;
    tok_d  = tok_i;
    // previous cell's product is compared here, one stage late
    if (tok_i.pend > tok_i.bestv) begin
      tok_d.bestv = tok_i.pend;
      tok_d.best  = tok_i.pidx;
    end
    tok_d.pend = dot[32] ? 32'(-dot) : 32'(dot);
    tok_d.pidx = IdxW'(IDX);
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.clr) begin
      count_d = '0;
    end else if (ctrl_i.shift) begin
      count_d = nbr_count_i;
    end else if (ctrl_i.inc && ctrl_i.sel == IdxW'(IDX) && count_q < CountW'(MAX_COUNT)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign tok_o   = tok_q;
  assign count_o = count_q;

endmodule
`default_nettype wire

[src/orientation_histogram_peaks.sv]
// Top level: cell row, ring scan and result sequencing of the orientation histogram.
`timescale 1ns / 1ps
`default_nettype none
// A point is accepted when start_i is high and busy_o low. The normal walks the row of
// NUM_DIRS cells, one cell per cycle, and its bin result is registered from the compare
// after the last cell. A point with last_point_i set adds one full rotation of the count
// ring to count peaks and a state for the point result; when peaks were found a second
// rotation reports them. After such a point the histogram is clear.
// Results come out as one-cycle pulses on result_valid_o; the receiver cannot stall them.
// Peak results follow the point result in increasing bin order.
module orientation_histogram_peaks import ohp_pkg::*; #(
  parameter int NUM_DIRS   = 32,
  parameter int MAX_GROUPS = 20,
  parameter int MAX_COUNT  = 65535
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output      logic                busy_o,
  input  wire logic signed [15:0]  normal_x_i,
  input  wire logic signed [15:0]  normal_y_i,
  input  wire logic                last_point_i,
  output      logic                result_valid_o,
  output      logic                kind_o,
  output      logic [IdxW-1:0]     bin_index_o,
  output      logic [SupportW-1:0] support_o,
  output      logic                overflow_o,
  output      logic                last_result_o
);

  localparam int CW = $clog2(NUM_DIRS);
  localparam int GW = $clog2(MAX_GROUPS + 2);

  token_t            tok [NUM_DIRS+1];
  logic [CountW-1:0] counts [NUM_DIRS];
  cell_ctrl_t        ctrl;

  state_e            state_d, state_q;
  logic [CW-1:0]     cnt_d, cnt_q;
  logic [GW-1:0]     total_d, total_q;
  logic [GW-1:0]     emitted_d, emitted_q;
  logic [GW-1:0]     limit;
  logic              last_d, last_q;
  logic [IdxW-1:0]   best_d, best_q;
  token_t            launch_d, launch_q;

  logic              rv_d, rv_q;
  logic              kind_d, kind_q;
  logic [IdxW-1:0]   bin_d, bin_q;
  logic [SupportW-1:0] sup_d, sup_q;
  logic              ovf_d, ovf_q;
  logic              lr_d, lr_q;

  logic [IdxW-1:0]     final_best;
  logic [SupportW-1:0] s_sum;
  logic [CountW-1:0]   c_l, c_c, c_r, diff;
  logic                is_peak;

  assign tok[0] = launch_q;

  for (genvar k = 0; k < NUM_DIRS; k++) begin : g_cell
    localparam bit              Neg = (2 * k > NUM_DIRS);
    localparam longint unsigned Kk  = Neg ? longint'(NUM_DIRS - k) : longint'(k);
    localparam longint unsigned Ang = (PiQ30 * Kk) / NUM_DIRS;
    // Q30 Taylor terms t^n/n! of the angle folded into the first quadrant
    localparam longint unsigned T1  = (OneQ30 * Ang) >> 30;
    localparam longint unsigned T2  = ((T1 * Ang) >> 30) / 2;
    localparam longint unsigned T3  = ((T2 * Ang) >> 30) / 3;
    localparam longint unsigned T4  = ((T3 * Ang) >> 30) / 4;
    localparam longint unsigned T5  = ((T4 * Ang) >> 30) / 5;
    localparam longint unsigned T6  = ((T5 * Ang) >> 30) / 6;
    localparam longint unsigned T7  = ((T6 * Ang) >> 30) / 7;
    localparam longint unsigned T8  = ((T7 * Ang) >> 30) / 8;
    localparam longint unsigned T9  = ((T8 * Ang) >> 30) / 9;
    localparam longint unsigned T10 = ((T9 * Ang) >> 30) / 10;
    localparam longint unsigned T11 = ((T10 * Ang) >> 30) / 11;
    localparam longint unsigned T12 = ((T11 * Ang) >> 30) / 12;
    localparam longint unsigned T13 = ((T12 * Ang) >> 30) / 13;
    localparam longint unsigned T14 = ((T13 * Ang) >> 30) / 14;
    localparam longint unsigned T15 = ((T14 * Ang) >> 30) / 15;
    localparam longint unsigned T16 = ((T15 * Ang) >> 30) / 16;
    localparam longint unsigned T17 = ((T16 * Ang) >> 30) / 17;
    localparam longint unsigned T18 = ((T17 * Ang) >> 30) / 18;
    localparam longint unsigned T19 = ((T18 * Ang) >> 30) / 19;
    localparam longint unsigned T20 = ((T19 * Ang) >> 30) / 20;
    localparam longint CSum = longint'(OneQ30) - longint'(T2) + longint'(T4)
                            - longint'(T6) + longint'(T8) - longint'(T10)
                            + longint'(T12) - longint'(T14) + longint'(T16)
                            - longint'(T18) + longint'(T20);
    localparam longint SSum = longint'(T1) - longint'(T3) + longint'(T5)
                            - longint'(T7) + longint'(T9) - longint'(T11)
                            + longint'(T13) - longint'(T15) + longint'(T17)
                            - longint'(T19);
    localparam logic signed [15:0] CosV = q15_sat(CSum);
    localparam logic signed [15:0] SinV = q15_sat(SSum);
    ohp_cell #(
      .IDX       (k),
      .COS       (Neg ? -CosV : CosV),
      .SIN       (SinV),
      .MAX_COUNT (MAX_COUNT)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .tok_i       (tok[k]),
      .tok_o       (tok[k+1]),
      .nbr_count_i (counts[(k + 1) % NUM_DIRS]),
      .count_o     (counts[k])
    );
  end

  // last stage compare, after the final cell
  always_comb begin
    final_best = tok[NUM_DIRS].best;
    if (tok[NUM_DIRS].pend > tok[NUM_DIRS].bestv) final_best = tok[NUM_DIRS].pidx;
  end

  // ring is rotated so that the scanned bin always sits in cell 0
  always_comb begin
    c_l     = counts[NUM_DIRS-1];
    c_c     = counts[0];
    c_r     = counts[1];
    s_sum   = SupportW'(c_l) + SupportW'(c_c) + SupportW'(c_r);
    diff    = (c_r > c_l) ? c_r - c_l : c_l - c_r;
    is_peak = (s_sum >= SupportW'(2)) && ({diff, 1'b0} <= s_sum) &&
              (c_c >= c_l) && (c_c >= c_r);
    limit   = (total_q > GW'(MAX_GROUPS)) ? GW'(MAX_GROUPS) : total_q;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    emitted_d = emitted_q;
    last_d    = last_q;
    best_d    = best_q;
    launch_d  = launch_q;
    ctrl      = '0;
    ctrl.sel  = final_best;
    rv_d      = 1'b0;
    kind_d    = 1'b0;
    bin_d     = best_q;
    sup_d     = '0;
    ovf_d     = 1'b0;
    lr_d      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          launch_d    = '0;
          launch_d.nx = normal_x_i;
          launch_d.ny = normal_y_i;
          last_d      = last_point_i;
          cnt_d       = '0;
          state_d     = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (cnt_q == CW'(NUM_DIRS - 1)) begin
          state_d = ST_INC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_INC: begin
        ctrl.inc = 1'b1;
        best_d   = final_best;
        cnt_d    = '0;
        total_d  = '0;
        if (last_q) begin
          state_d = ST_SCAN1;
        end else begin
          rv_d    = 1'b1;
          bin_d   = final_best;
          lr_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN1: begin
        ctrl.shift = 1'b1;
        if (is_peak && total_q <= GW'(MAX_GROUPS)) total_d = total_q + 1'b1;
        if (cnt_q == CW'(NUM_DIRS - 1)) begin
          state_d = ST_POINT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_POINT: begin
        rv_d      = 1'b1;
        bin_d     = best_q;
        lr_d      = (total_q == '0);
        cnt_d     = '0;
        emitted_d = '0;
        if (total_q == '0) begin
          ctrl.clr = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_SCAN2;
        end
      end
      ST_SCAN2: begin
        ctrl.shift = 1'b1;
        if (is_peak && emitted_q < GW'(MAX_GROUPS)) begin
          rv_d      = 1'b1;
          kind_d    = 1'b1;
          bin_d     = IdxW'(cnt_q);
          sup_d     = s_sum;
          ovf_d     = (total_q > GW'(MAX_GROUPS));
          lr_d      = (emitted_q + 1'b1 == limit);
          emitted_d = emitted_q + 1'b1;
        end
        if (cnt_q == CW'(NUM_DIRS - 1)) begin
          ctrl.clr = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      total_q   <= '0;
      emitted_q <= '0;
      last_q    <= 1'b0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      total_q   <= total_d;
      emitted_q <= emitted_d;
      last_q    <= last_d;
      rv_q      <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    launch_q <= launch_d;
    best_q   <= best_d;
    kind_q   <= kind_d;
    bin_q    <= bin_d;
    sup_q    <= sup_d;
    ovf_q    <= ovf_d;
    lr_q     <= lr_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign kind_o         = kind_q;
  assign bin_index_o    = bin_q;
  assign support_o      = sup_q;
  assign overflow_o     = ovf_q;
  assign last_result_o  = lr_q;

endmodule
`default_nettype wire
